// ===== rtl/core/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared codes and control/status types for the two-way substring search.
// ----------------------------------------------------------------------------
package tws_pkg;

    // input item actions
    localparam logic [1:0] ACT_NEEDLE = 2'd0;
    localparam logic [1:0] ACT_TEXT   = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    // datapath operations
    localparam logic [4:0] OP_IDLE    = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_MS_INIT = 5'd2;
    localparam logic [4:0] OP_MS_RD   = 5'd3;
    localparam logic [4:0] OP_MS_UPD  = 5'd4;
    localparam logic [4:0] OP_MS_END  = 5'd5;
    localparam logic [4:0] OP_PR_RD   = 5'd6;
    localparam logic [4:0] OP_PR_NEXT = 5'd7;
    localparam logic [4:0] OP_M_INIT  = 5'd8;
    localparam logic [4:0] OP_M_START = 5'd9;
    localparam logic [4:0] OP_R_RD    = 5'd10;
    localparam logic [4:0] OP_R_NEXT  = 5'd11;
    localparam logic [4:0] OP_R_MISS  = 5'd12;
    localparam logic [4:0] OP_L_INIT  = 5'd13;
    localparam logic [4:0] OP_L_RD    = 5'd14;
    localparam logic [4:0] OP_L_NEXT  = 5'd15;
    localparam logic [4:0] OP_L_MISS  = 5'd16;
    localparam logic [4:0] OP_FIN     = 5'd17;

    // result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [4:0] op;
        logic       less;
        logic       periodic;
        logic [1:0] kind;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic short_text;
        logic ms_more;
        logic pr_done;
        logic pr_bound;
        logic a_eq;
        logic m_more;
        logic r_more;
        logic l_more;
        logic t_eq;
    } status_t;

endpackage

// ===== rtl/core/tws_ram.sv =====
// ----------------------------------------------------------------------------
// tws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tws_dp.sv =====
// ----------------------------------------------------------------------------
// tws_dp
// Datapath: needle and text stores, index registers, compares and result.
// ----------------------------------------------------------------------------
module tws_dp #(
    parameter int MAX_NEEDLE = 64,
    parameter int MAX_TEXT   = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tws_pkg::cmd_t    cmd,
    input  logic [1:0]       action,
    input  logic [7:0]       data_byte,
    output tws_pkg::status_t status,
    output logic             found,
    output logic [11:0]      match_position,
    output logic             overflow
);
    import tws_pkg::*;

    localparam int NAW = $clog2(MAX_NEEDLE);
    localparam int TAW = $clog2(MAX_TEXT);
    localparam int NLW = $clog2(MAX_NEEDLE + 1);
    localparam int TLW = $clog2(MAX_TEXT + 1);
    localparam int W   = $clog2(MAX_TEXT + 2 * MAX_NEEDLE) + 2;

    logic [NLW-1:0] nlen_reg, nlen_next;
    logic [TLW-1:0] tlen_reg, tlen_next;
    logic           dropped_reg, dropped_next;

    logic signed [W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, p_reg, p_next;
    logic signed [W-1:0] s1_reg, s1_next, p1_reg, p1_next;
    logic signed [W-1:0] idx_reg, idx_next, per_reg, per_next, mem_reg, mem_next;
    logic                periodic_reg, periodic_next;
    logic                found_reg, found_next, ovf_reg, ovf_next;
    logic [11:0]         pos_reg, pos_next;

    logic signed [W-1:0] n_s, len_s, excess, a_idx, b_idx, t_pos, jk, idx1;
    logic [7:0]          a_dat, b_dat, t_dat;
    logic                n_we, t_we, better;

    assign n_s    = $signed({{(W-NLW){1'b0}}, nlen_reg});
    assign len_s  = $signed({{(W-TLW){1'b0}}, tlen_reg});
    assign excess = len_s - n_s;
    assign jk     = j_reg + k_reg;
    assign idx1   = idx_reg + W'(1);

    // write enables for appends
    assign n_we = (cmd.op == OP_LOAD) && (action == ACT_NEEDLE)
                  && (nlen_reg < NLW'(MAX_NEEDLE));
    assign t_we = (cmd.op == OP_LOAD) && (action == ACT_TEXT)
                  && (tlen_reg < TLW'(MAX_TEXT));

    // read addresses
    always_comb
    begin
        a_idx = i_reg;
        b_idx = i_reg + k_reg;
        t_pos = i_reg + j_reg;
        if (cmd.op == OP_MS_RD)
        begin
            a_idx = jk;
        end
        else if (cmd.op == OP_PR_RD)
        begin
            a_idx = k_reg;
            b_idx = k_reg + per_reg;
        end
    end

    tws_ram #(.WIDTH(8), .DEPTH(MAX_NEEDLE)) u_needle_a (
        .clk(clk), .we(n_we), .waddr(nlen_reg[NAW-1:0]), .wdata(data_byte),
        .raddr(a_idx[NAW-1:0]), .rdata(a_dat)
    );

    tws_ram #(.WIDTH(8), .DEPTH(MAX_NEEDLE)) u_needle_b (
        .clk(clk), .we(n_we), .waddr(nlen_reg[NAW-1:0]), .wdata(data_byte),
        .raddr(b_idx[NAW-1:0]), .rdata(b_dat)
    );

    tws_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text (
        .clk(clk), .we(t_we), .waddr(tlen_reg[TAW-1:0]), .wdata(data_byte),
        .raddr(t_pos[TAW-1:0]), .rdata(t_dat)
    );

    assign better = cmd.less ? (a_dat < b_dat) : (a_dat > b_dat);

    // status back to the controller
    always_comb
    begin
        status.empty      = (nlen_reg == '0);
        status.short_text = (len_s < n_s);
        status.ms_more    = (jk < n_s);
        status.pr_done    = (k_reg > idx_reg);
        status.pr_bound   = ((k_reg + per_reg) >= n_s);
        status.a_eq       = (a_dat == b_dat);
        status.m_more     = (j_reg <= excess);
        status.r_more     = (i_reg < n_s);
        status.l_more     = (i_reg >= mem_reg);
        status.t_eq       = (a_dat == t_dat);
    end

    // register updates per operation
    always_comb
    begin
        nlen_next     = nlen_reg;
        tlen_next     = tlen_reg;
        dropped_next  = dropped_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        s1_next       = s1_reg;
        p1_next       = p1_reg;
        idx_next      = idx_reg;
        per_next      = per_reg;
        mem_next      = mem_reg;
        periodic_next = periodic_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        ovf_next      = ovf_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                if (n_we)
                begin
                    nlen_next = nlen_reg + NLW'(1);
                end
                else if (t_we)
                begin
                    tlen_next = tlen_reg + TLW'(1);
                end
                else if (action == ACT_NEEDLE || action == ACT_TEXT)
                begin
                    dropped_next = 1'b1;
                end
            end
            OP_MS_INIT:
            begin
                i_next = '1;
                j_next = '0;
                k_next = W'(1);
                p_next = W'(1);
            end
            OP_MS_UPD:
            begin
                if (better)
                begin
                    j_next = jk;
                    k_next = W'(1);
                    p_next = jk - i_reg;
                end
                else if (a_dat == b_dat)
                begin
                    if (k_reg == p_reg)
                    begin
                        j_next = j_reg + p_reg;
                        k_next = W'(1);
                    end
                    else
                    begin
                        k_next = k_reg + W'(1);
                    end
                end
                else
                begin
                    i_next = j_reg;
                    j_next = j_reg + W'(1);
                    p_next = W'(1);
                    k_next = W'(1);
                end
            end
            OP_MS_END:
            begin
                if (cmd.less)
                begin
                    // save first pass, restart for the other order
                    s1_next = i_reg;
                    p1_next = p_reg;
                    i_next  = '1;
                    j_next  = '0;
                    k_next  = W'(1);
                    p_next  = W'(1);
                end
                else
                begin
                    // keep the later split
                    if (s1_reg >= i_reg)
                    begin
                        idx_next = s1_reg;
                        per_next = p1_reg;
                    end
                    else
                    begin
                        idx_next = i_reg;
                        per_next = p_reg;
                    end
                    k_next = '0;
                end
            end
            OP_PR_NEXT:
            begin
                k_next = k_reg + W'(1);
            end
            OP_M_INIT:
            begin
                j_next        = '0;
                mem_next      = '0;
                periodic_next = cmd.periodic;
            end
            OP_M_START:
            begin
                i_next = (idx1 > mem_reg) ? idx1 : mem_reg;
            end
            OP_R_NEXT:
            begin
                i_next = i_reg + W'(1);
            end
            OP_R_MISS:
            begin
                j_next   = j_reg + i_reg - idx_reg;
                mem_next = '0;
            end
            OP_L_INIT:
            begin
                i_next = idx_reg;
            end
            OP_L_NEXT:
            begin
                i_next = i_reg - W'(1);
            end
            OP_L_MISS:
            begin
                j_next   = j_reg + per_reg;
                mem_next = periodic_reg ? (n_s - per_reg) : '0;
            end
            OP_FIN:
            begin
                found_next   = (cmd.kind != KIND_NONE);
                pos_next     = (cmd.kind == KIND_FOUND) ? 12'(j_reg) : 12'd0;
                ovf_next     = dropped_reg;
                nlen_next    = '0;
                tlen_next    = '0;
                dropped_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nlen_reg    <= '0;
            tlen_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            nlen_reg    <= nlen_next;
            tlen_reg    <= tlen_next;
            dropped_reg <= dropped_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        p_reg        <= p_next;
        s1_reg       <= s1_next;
        p1_reg       <= p1_next;
        idx_reg      <= idx_next;
        per_reg      <= per_next;
        mem_reg      <= mem_next;
        periodic_reg <= periodic_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        ovf_reg      <= ovf_next;
    end

    assign found          = found_reg;
    assign match_position = pos_reg;
    assign overflow       = ovf_reg;

endmodule

// ===== rtl/core/tws_ctrl.sv =====
// ----------------------------------------------------------------------------
// tws_ctrl
// Controller: sequences loading, factorization, repeat check and matching.
// ----------------------------------------------------------------------------
module tws_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       action,
    output logic             out_valid,
    input  logic             out_ready,
    input  tws_pkg::status_t status,
    output tws_pkg::cmd_t    cmd
);
    import tws_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MS_CHK  = 4'd1;
    localparam logic [3:0] S_MS_EVAL = 4'd2;
    localparam logic [3:0] S_PR_CHK  = 4'd3;
    localparam logic [3:0] S_PR_EVAL = 4'd4;
    localparam logic [3:0] S_M_CHK   = 4'd5;
    localparam logic [3:0] S_R_CHK   = 4'd6;
    localparam logic [3:0] S_R_EVAL  = 4'd7;
    localparam logic [3:0] S_L_CHK   = 4'd8;
    localparam logic [3:0] S_L_EVAL  = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic [1:0] kind_reg, kind_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = ovalid_reg;

    // next state and command
    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        kind_next    = kind_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        cmd.op       = OP_IDLE;
        cmd.less     = pass_reg;
        cmd.periodic = 1'b0;
        cmd.kind     = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action != ACT_SEARCH)
                    begin
                        cmd.op = OP_LOAD;
                    end
                    else if (status.empty)
                    begin
                        kind_next  = KIND_EMPTY;
                        state_next = S_FIN;
                    end
                    else if (status.short_text)
                    begin
                        kind_next  = KIND_NONE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.op     = OP_MS_INIT;
                        pass_next  = 1'b1;
                        state_next = S_MS_CHK;
                    end
                end
            end
            S_MS_CHK:
            begin
                if (status.ms_more)
                begin
                    cmd.op     = OP_MS_RD;
                    state_next = S_MS_EVAL;
                end
                else
                begin
                    cmd.op = OP_MS_END;
                    if (pass_reg)
                    begin
                        pass_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_PR_CHK;
                    end
                end
            end
            S_MS_EVAL:
            begin
                cmd.op     = OP_MS_UPD;
                state_next = S_MS_CHK;
            end
            S_PR_CHK:
            begin
                priority if (status.pr_done)
                begin
                    cmd.op       = OP_M_INIT;
                    cmd.periodic = 1'b1;
                    state_next   = S_M_CHK;
                end
                else if (status.pr_bound)
                begin
                    cmd.op     = OP_M_INIT;
                    state_next = S_M_CHK;
                end
                else
                begin
                    cmd.op     = OP_PR_RD;
                    state_next = S_PR_EVAL;
                end
            end
            S_PR_EVAL:
            begin
                if (status.a_eq)
                begin
                    cmd.op     = OP_PR_NEXT;
                    state_next = S_PR_CHK;
                end
                else
                begin
                    cmd.op     = OP_M_INIT;
                    state_next = S_M_CHK;
                end
            end
            S_M_CHK:
            begin
                if (status.m_more)
                begin
                    cmd.op     = OP_M_START;
                    state_next = S_R_CHK;
                end
                else
                begin
                    kind_next  = KIND_NONE;
                    state_next = S_FIN;
                end
            end
            S_R_CHK:
            begin
                if (status.r_more)
                begin
                    cmd.op     = OP_R_RD;
                    state_next = S_R_EVAL;
                end
                else
                begin
                    cmd.op     = OP_L_INIT;
                    state_next = S_L_CHK;
                end
            end
            S_R_EVAL:
            begin
                if (status.t_eq)
                begin
                    cmd.op     = OP_R_NEXT;
                    state_next = S_R_CHK;
                end
                else
                begin
                    cmd.op     = OP_R_MISS;
                    state_next = S_M_CHK;
                end
            end
            S_L_CHK:
            begin
                if (status.l_more)
                begin
                    cmd.op     = OP_L_RD;
                    state_next = S_L_EVAL;
                end
                else
                begin
                    kind_next  = KIND_FOUND;
                    state_next = S_FIN;
                end
            end
            S_L_EVAL:
            begin
                if (status.t_eq)
                begin
                    cmd.op     = OP_L_NEXT;
                    state_next = S_L_CHK;
                end
                else
                begin
                    cmd.op     = OP_L_MISS;
                    state_next = S_M_CHK;
                end
            end
            S_FIN:
            begin
                // hold until the result register is free
                if (!ovalid_reg || out_ready)
                begin
                    cmd.op      = OP_FIN;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pass_reg   <= 1'b0;
            kind_reg   <= KIND_NONE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            kind_reg   <= kind_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== rtl/core/two_way_substring_search.sv =====
// ----------------------------------------------------------------------------
// two_way_substring_search
// Two-way (critical factorization) substring search over loaded byte stores.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_ready  | action, data_byte
//  out     | out_valid / out_ready| found, match_position, overflow
//
//  An append item is written straight from the idle state. A search runs the
//  two maximal-suffix passes and the repeat check over needle bytes, closes
//  each pass, then walks the matcher over text/needle bytes per window
//  position, right part first and then the left part, and delivers; every
//  compare waits on one registered RAM read. An empty needle or a short text
//  goes straight to delivery. Reset clears the lengths, the drop flag and the
//  result valid; the stores are not cleared. A stalled result holds in the
//  output register; appends are taken meanwhile and the next search waits to
//  finish until the result is taken.
// ----------------------------------------------------------------------------
module two_way_substring_search #(
    parameter int MAX_NEEDLE = 64,
    parameter int MAX_TEXT   = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [11:0] match_position,
    output logic        overflow
);
    import tws_pkg::*;

    cmd_t    cmd;
    status_t status;

    tws_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .cmd(cmd)
    );

    tws_dp #(.MAX_NEEDLE(MAX_NEEDLE), .MAX_TEXT(MAX_TEXT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .action(action),
        .data_byte(data_byte), .status(status), .found(found),
        .match_position(match_position), .overflow(overflow)
    );

endmodule

// ===== rtl/core/tws_chk.sv =====
// ----------------------------------------------------------------------------
// tws_chk
// Port-level checker for the two-way substring search, bound to the top.
// ----------------------------------------------------------------------------
module tws_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [11:0] match_position,
    input logic        overflow
);
    import tws_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
        && $stable(match_position) && $stable(overflow))
        else $error("stalled result changed");

    // not found reports position zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_position == 12'd0)
        else $error("position set without a match");

    // a search leaves the input side busy
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_SEARCH |=> !in_ready)
        else $error("search item did not occupy the block");

    // a new result follows a busy cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a search");

endmodule

bind two_way_substring_search tws_chk u_chk (.*);

// ===== tb/two_way_substring_search_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_substring_search_test
// Streams needle and text bytes into the substring search block, issues
// search commands and checks each reported match against an independent
// two-way search model kept in this bench.
// ----------------------------------------------------------------------------
module two_way_substring_search_test;
    import tws_pkg::*;

    localparam int NEEDLE_CAP = 64;
    localparam int TEXT_CAP   = 4096;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic        found;
        logic [11:0] pos;
        logic        ovf;
    } match_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [11:0] match_position;
    logic        overflow;

    // bench copy of the block state
    logic [7:0] needle_img [NEEDLE_CAP];
    logic [7:0] text_img [TEXT_CAP];
    int         needle_len;
    int         text_len;
    bit         dropped;

    match_t     pending_matches [$];
    int         error_count;
    int         searches_sent;
    int         matches_seen;
    int         items_sent;
    longint     cycle_count;
    bit         no_gaps;

    two_way_substring_search i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_position (match_position),
        .overflow       (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // maximal suffix of the needle under one byte order
    function automatic int suffix_split(bit use_less, int n, output int per);
        int i;
        int j;
        int k;
        int p;
        logic [7:0] a;
        logic [7:0] b;
        bit better;
        i = -1;
        j = 0;
        k = 1;
        p = 1;
        while (j + k < n)
        begin
            a = needle_img[j + k];
            b = needle_img[i + k];
            better = use_less ? (a < b) : (a > b);
            if (better)
            begin
                j += k;
                k = 1;
                p = j - i;
            end
            else if (a == b)
            begin
                if (k == p)
                begin
                    j += p;
                    k = 1;
                end
                else
                    k++;
            end
            else
            begin
                i = j;
                j++;
                p = 1;
                k = 1;
            end
        end
        per = p;
        return i;
    endfunction

    // first match offset of the needle in the text, or -1
    function automatic int locate_needle();
        int n;
        int excess;
        int per;
        int per2;
        int idx;
        int idx2;
        int i;
        int j;
        int mem;
        bit repeats;
        n = needle_len;
        if (n == 0)
            return 0;
        if (text_len < n)
            return -1;
        excess = text_len - n;
        idx = suffix_split(1'b1, n, per);
        idx2 = suffix_split(1'b0, n, per2);
        if (idx2 > idx)
        begin
            idx = idx2;
            per = per2;
        end
        repeats = 1'b1;
        for (int k = 0; k <= idx; k++)
        begin
            if (k + per >= n || needle_img[k] != needle_img[k + per])
            begin
                repeats = 1'b0;
                break;
            end
        end
        j = 0;
        mem = 0;
        while (j <= excess)
        begin
            i = (repeats && mem > idx + 1) ? mem : idx + 1;
            while (i < n && needle_img[i] == text_img[i + j])
                i++;
            if (i < n)
            begin
                j += i - idx;
                mem = 0;
            end
            else
            begin
                i = idx;
                if (repeats)
                begin
                    while (i >= mem && needle_img[i] == text_img[i + j])
                        i--;
                    if (i < mem)
                        return j;
                    mem = n - per;
                end
                else
                begin
                    while (i >= 0 && needle_img[i] == text_img[i + j])
                        i--;
                    if (i < 0)
                        return j;
                end
                j += per;
            end
        end
        return -1;
    endfunction

    // update the bench state for one accepted item
    task automatic apply_item(logic [1:0] act, logic [7:0] b);
        int pos;
        match_t m;
        case (act)
            ACT_NEEDLE:
            begin
                if (needle_len < NEEDLE_CAP)
                    needle_img[needle_len++] = b;
                else
                    dropped = 1'b1;
            end
            ACT_TEXT:
            begin
                if (text_len < TEXT_CAP)
                    text_img[text_len++] = b;
                else
                    dropped = 1'b1;
            end
            ACT_SEARCH:
            begin
                pos = locate_needle();
                m.found = (pos >= 0);
                m.pos = (pos >= 0) ? pos[11:0] : 12'd0;
                m.ovf = dropped;
                pending_matches.push_back(m);
                searches_sent++;
                needle_len = 0;
                text_len = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    // send one item after a random gap, then hold until accepted
    task automatic send_item(logic [1:0] act, logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_item(act, b);
        items_sent++;
    endtask

    // load needle and text in random interleave, with optional noise, then search
    task automatic run_case(logic [7:0] ndl [$], logic [7:0] txt [$], bit noisy);
        int ni;
        int ti;
        ni = 0;
        ti = 0;
        while (ni < ndl.size() || ti < txt.size())
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(ACT_UNUSED, 8'($urandom_range(0, 255)));
            if (ti >= txt.size() || (ni < ndl.size() && $urandom_range(0, 1)))
                send_item(ACT_NEEDLE, ndl[ni++]);
            else
                send_item(ACT_TEXT, txt[ti++]);
        end
        send_item(ACT_SEARCH, 8'($urandom_range(0, 255)));
    endtask

    // wait until every expected result has been taken
    task automatic drain_results();
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte(int alphabet);
        case (alphabet)
            0: return 8'h61 + 8'($urandom_range(0, 1));
            1: return 8'h61 + 8'($urandom_range(0, 2));
            2: return 8'($urandom_range(0, 255));
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    task automatic test_directed();
        logic [7:0] ndl [$];
        logic [7:0] txt [$];
        // empty needle, empty text
        run_case(ndl, txt, 1'b0);
        // empty needle with text
        txt = '{8'h00, 8'hFF};
        run_case(ndl, txt, 1'b0);
        // text shorter than needle
        ndl = '{8'h01, 8'h02, 8'h03};
        txt = '{8'h01, 8'h02};
        run_case(ndl, txt, 1'b0);
        // byte extremes, match at the end
        ndl = '{8'hFF, 8'h00};
        txt = '{8'h00, 8'hFF, 8'hFF, 8'h00};
        run_case(ndl, txt, 1'b0);
        // periodic needle
        ndl = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
        txt = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h62, 8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
        run_case(ndl, txt, 1'b0);
        // ignored action between loads
        send_item(ACT_UNUSED, 8'hA5);
        ndl = '{8'h7A};
        txt = '{8'h7A};
        run_case(ndl, txt, 1'b0);
    endtask

    task automatic test_needle_overflow();
        logic [7:0] ndl [$];
        logic [7:0] txt [$];
        for (int k = 0; k < NEEDLE_CAP + 3; k++)
            ndl.push_back(8'h41);
        for (int k = 0; k < NEEDLE_CAP + 5; k++)
            txt.push_back(8'h41);
        run_case(ndl, txt, 1'b0);
    endtask

    // wait for every result, then keep the sender quiet for a while
    task automatic test_pause_until_drained();
        logic [7:0] ndl [$];
        logic [7:0] txt [$];
        ndl = '{8'h10, 8'h20};
        txt = '{8'h20, 8'h10, 8'h20};
        run_case(ndl, txt, 1'b0);
        in_valid <= 1'b0;
        drain_results();
        repeat (40) @(posedge clk);
        run_case(ndl, txt, 1'b0);
    endtask

    task automatic test_random_searches();
        logic [7:0] ndl [$];
        logic [7:0] txt [$];
        int nlen;
        int tlen;
        int alphabet;
        int at;
        while (items_sent < 1700)
        begin
            ndl.delete();
            txt.delete();
            // mostly short needles; an occasional one near or past the store size
            nlen = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(0, 8);
            tlen = $urandom_range(0, 40);
            alphabet = $urandom_range(0, 3);
            // switch idle gaps off for some stretches
            no_gaps = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < nlen; k++)
                ndl.push_back(pick_byte(alphabet));
            for (int k = 0; k < tlen; k++)
                txt.push_back(pick_byte(alphabet));
            // plant the needle in the text half the time when it fits
            if (tlen >= nlen && $urandom_range(0, 1))
            begin
                at = $urandom_range(0, tlen - nlen);
                for (int k = 0; k < nlen; k++)
                    txt[at + k] = ndl[k];
            end
            run_case(ndl, txt, 1'b1);
        end
        no_gaps = 1'b0;
    endtask

    // receiver: stall for a random time before each result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // compare each taken result with the oldest expected one
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && out_valid && out_ready)
        begin
            matches_seen++;
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d pos=%0d ovf=%0d",
                         $time, found, match_position, overflow);
                error_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0d actual %0d", $time, want.found, found);
                    error_count++;
                end
                if (match_position !== want.pos)
                begin
                    $display("%0t: match_position expected %0d actual %0d",
                             $time, want.pos, match_position);
                    error_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $display("%0t: overflow expected %0d actual %0d", $time, want.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_NEEDLE;
        data_byte   = 8'h00;
        needle_len  = 0;
        text_len    = 0;
        dropped     = 1'b0;
        error_count = 0;
        searches_sent = 0;
        matches_seen  = 0;
        items_sent  = 0;
        cycle_count = 0;
        no_gaps     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_needle_overflow();
        test_pause_until_drained();
        test_random_searches();

        in_valid <= 1'b0;
        drain_results();
        repeat (100) @(posedge clk);

        $display("Sent %0d items with %0d searches; checked %0d results.",
                 items_sent, searches_sent, matches_seen);
        $display("Covered empty and short cases, periodic needles and needle store overflow.");
        if (error_count == 0 && pending_matches.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
